// ===== hw/rtl/ssdr_pkg.sv =====
// Shared constants, types and helper functions for the seven-segment digit reader.
package ssdr_pkg;

   // Image geometry and pixel coding
   localparam int DIM_W = 10;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'((2 ** DIM_W) - 1);
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_LIT = 8'd255;
   localparam logic [PIX_W-1:0] PIX_DARK = 8'd0;
   localparam int SEG_W = 7;
   localparam int DIGIT_W = 4;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_HEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_WIDTH = 1'd1;

   // Register reset values
   localparam int RST_H = 64;
   localparam int RST_W = 32;

   // Reciprocal scale for constant division: q ~= (v * num * floor(2^16 / d)) >> 16
   localparam int RECIP_SH = 16;
   localparam int KC_W = 16;
   localparam logic [KC_W-1:0] K_H_THIRD = KC_W'(1 * ((2 ** RECIP_SH) / 3));
   localparam logic [KC_W-1:0] K_H_TWO_THIRD = KC_W'(2 * ((2 ** RECIP_SH) / 3));
   localparam logic [KC_W-1:0] K_H_MID_LO = KC_W'(7 * ((2 ** RECIP_SH) / 15));
   localparam logic [KC_W-1:0] K_H_MID_HI = KC_W'(8 * ((2 ** RECIP_SH) / 15));
   localparam logic [KC_W-1:0] K_H_TOP_MIN = KC_W'(1 * ((2 ** RECIP_SH) / 10));
   localparam logic [KC_W-1:0] K_H_BOT_MIN = KC_W'(1 * ((2 ** RECIP_SH) / 15));
   localparam logic [KC_W-1:0] K_H_ONE_MIN = KC_W'(9 * ((2 ** RECIP_SH) / 10));
   localparam logic [KC_W-1:0] K_W_MID_LO = KC_W'(4 * ((2 ** RECIP_SH) / 9));
   localparam logic [KC_W-1:0] K_W_MID_HI = KC_W'(5 * ((2 ** RECIP_SH) / 9));
   localparam logic [KC_W-1:0] K_W_SIDE_MIN = KC_W'(1 * ((2 ** RECIP_SH) / 6));

   // Side probe counter slots
   localparam int SIDE_UL = 0;
   localparam int SIDE_UR = 1;
   localparam int SIDE_LL = 2;
   localparam int SIDE_LR = 3;

   // Segment bit positions
   localparam int SEG_TOP = 0;
   localparam int SEG_MID = 1;
   localparam int SEG_BOT = 2;
   localparam int SEG_UL = 3;
   localparam int SEG_UR = 4;
   localparam int SEG_LL = 5;
   localparam int SEG_LR = 6;

   // Segment patterns of the known digits
   localparam logic [SEG_W-1:0] PAT_ALL = 7'h7F;
   localparam logic [SEG_W-1:0] PAT_D0 = 7'h7D;
   localparam logic [SEG_W-1:0] PAT_D2 = 7'h37;
   localparam logic [SEG_W-1:0] PAT_D3 = 7'h57;
   localparam logic [SEG_W-1:0] PAT_D4 = 7'h5A;
   localparam logic [SEG_W-1:0] PAT_D5 = 7'h4F;
   localparam logic [SEG_W-1:0] PAT_D6 = 7'h6F;
   localparam logic [SEG_W-1:0] PAT_D7 = 7'h51;
   localparam logic [SEG_W-1:0] PAT_D9 = 7'h5F;

   // Height derived thresholds
   typedef struct packed {
      logic [DIM_W-1:0] third;
      logic [DIM_W-1:0] two_third;
      logic [DIM_W-1:0] mid_lo;
      logic [DIM_W-1:0] mid_hi;
      logic [DIM_W-1:0] top_min;
      logic [DIM_W-1:0] bot_min;
      logic [DIM_W-1:0] one_min;
   } hthr_type;

   // Width derived thresholds
   typedef struct packed {
      logic [DIM_W-1:0] mid_lo;
      logic [DIM_W-1:0] mid_hi;
      logic [DIM_W-1:0] side_min;
   } wthr_type;

   localparam hthr_type HTHR_RST = '{
      third:     DIM_W'(RST_H / 3),
      two_third: DIM_W'((RST_H * 2) / 3),
      mid_lo:    DIM_W'((RST_H * 7) / 15),
      mid_hi:    DIM_W'((RST_H * 8) / 15),
      top_min:   DIM_W'(RST_H / 10),
      bot_min:   DIM_W'(RST_H / 15),
      one_min:   DIM_W'((RST_H * 9) / 10)
   };

   localparam wthr_type WTHR_RST = '{
      mid_lo:   DIM_W'((RST_W * 4) / 9),
      mid_hi:   DIM_W'((RST_W * 5) / 9),
      side_min: DIM_W'(RST_W / 6)
   };

   // Quotient estimate, at most one below the true quotient
   function automatic logic [DIM_W-1:0] quot_est(input logic [DIM_W-1:0] v,
                                                 input logic [KC_W-1:0] k);
      logic [DIM_W+KC_W-1:0] prod;
      prod = {{KC_W{1'b0}}, v} * {{DIM_W{1'b0}}, k};
      return prod[DIM_W+KC_W-1:RECIP_SH];
   endfunction

   // Correct the estimate by one compare and subtract
   function automatic logic [DIM_W-1:0] quot_fix(input logic [DIM_W-1:0] v,
                                                 input logic [3:0] num,
                                                 input logic [3:0] d,
                                                 input logic [DIM_W-1:0] est);
      logic [DIM_W+3:0] x;
      logic [DIM_W+3:0] p;
      logic [DIM_W+3:0] rem;
      x = {4'b0, v} * {{DIM_W{1'b0}}, num};
      p = {4'b0, est} * {{DIM_W{1'b0}}, d};
      rem = x - p;
      return (rem >= {{DIM_W{1'b0}}, d}) ? est + 1'b1 : est;
   endfunction

   // Count up, holding at the top
   function automatic logic [DIM_W-1:0] sat_inc(input logic [DIM_W-1:0] v);
      return (v == DIM_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/seven_segment_digit_reader.sv =====
// Seven-segment digit reader: probe counting over a raster image and digit decode.
//
// Usage
//   req_* carries one grey pixel per request in raster order; req_last marks the final
//   pixel of an image. rsp_* carries one result per image: the decoded digit, a
//   recognised flag and the seven segment flags. csr_* writes roi_height (index 0)
//   and roi_width (index 1); a value of 0 acts as 1. Write them only while idle.
//   Throughput: one pixel per clock unless a last pixel waits on a stalled result. A
//   request passes an input register and one stage of probe logic into the result
//   register, which raises rsp_valid. Threshold values (thirds, sixths, ninths,
//   tenths, fifteenths of the sizes) are rebuilt from a reciprocal estimate and a
//   one-step correction in the cycle after a register write, ready for a request
//   accepted on the next edge. Reset restores roi_height 64, roi_width 32, clears the
//   position and all probe counters, and empties both pipeline registers.
//   When rsp_stall holds a result, pixels without last keep flowing; a last pixel
//   waits in the input register and req_stall rises until the result is taken.
module seven_segment_digit_reader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ssdr_pkg::PIX_W-1:0]          req_pixel,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ssdr_pkg::DIGIT_W-1:0]        rsp_digit,
   output logic                                rsp_recognized,
   output logic [ssdr_pkg::SEG_W-1:0]          rsp_segments,
   input  logic                                csr_write_enable,
   input  logic [ssdr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssdr_pkg::DIM_W-1:0]          csr_wdata
);

   localparam int DW = ssdr_pkg::DIM_W;

   // Configuration and threshold registers
   logic [DW-1:0]        h_ff, w_ff;
   ssdr_pkg::hthr_type   hest_ff, hthr_ff, hthr_in;
   ssdr_pkg::wthr_type   west_ff, wthr_ff, wthr_in;
   logic [DW-1:0]        csr_dim;

   // Input register
   logic                        in_valid_ff, in_valid_in;
   logic [ssdr_pkg::PIX_W-1:0]  in_pixel_ff;
   logic                        in_last_ff;

   // Frame state
   logic [DW-1:0] row_ff, row_in, col_ff, col_in;
   logic [DW-1:0] top_ff, top_in, bot_ff, bot_in, full_ff, full_in;
   logic [DW-1:0] side_ff [4];
   logic [DW-1:0] side_in [4];
   logic          mid_ff, mid_in;

   // Updated values before the end-of-image clear
   logic [DW-1:0] row_upd, col_upd, top_upd, bot_upd, full_upd;
   logic [DW-1:0] side_upd [4];
   logic          mid_upd;

   // Result register
   logic                          rsp_valid_ff;
   logic [ssdr_pkg::DIGIT_W-1:0]  rsp_digit_ff, digit_in;
   logic                          rsp_rec_ff, rec_in;
   logic [ssdr_pkg::SEG_W-1:0]    rsp_seg_ff, seg_in;

   logic          req_acc, proc, rsp_free, frame_end;
   logic          pix_lit, pix_dark, in_roi, in_window;
   logic [DW-1:0] half;

   // Handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && (!in_last_ff || rsp_free);
   assign frame_end = proc && in_last_ff;
   assign req_stall = in_valid_ff && !proc;
   assign req_acc   = req_valid && !req_stall;
   assign in_valid_in = req_acc || (in_valid_ff && !proc);

   // Sizes: zero acts as one
   assign csr_dim = (csr_wdata == '0) ? DW'(1) : csr_wdata;

   // Finish the constant divisions from the estimates
   always_comb begin
      hthr_in.third     = ssdr_pkg::quot_fix(h_ff, 4'd1, 4'd3,  hest_ff.third);
      hthr_in.two_third = ssdr_pkg::quot_fix(h_ff, 4'd2, 4'd3,  hest_ff.two_third);
      hthr_in.mid_lo    = ssdr_pkg::quot_fix(h_ff, 4'd7, 4'd15, hest_ff.mid_lo);
      hthr_in.mid_hi    = ssdr_pkg::quot_fix(h_ff, 4'd8, 4'd15, hest_ff.mid_hi);
      hthr_in.top_min   = ssdr_pkg::quot_fix(h_ff, 4'd1, 4'd10, hest_ff.top_min);
      hthr_in.bot_min   = ssdr_pkg::quot_fix(h_ff, 4'd1, 4'd15, hest_ff.bot_min);
      hthr_in.one_min   = ssdr_pkg::quot_fix(h_ff, 4'd9, 4'd10, hest_ff.one_min);
      wthr_in.mid_lo    = ssdr_pkg::quot_fix(w_ff, 4'd4, 4'd9,  west_ff.mid_lo);
      wthr_in.mid_hi    = ssdr_pkg::quot_fix(w_ff, 4'd5, 4'd9,  west_ff.mid_hi);
      wthr_in.side_min  = ssdr_pkg::quot_fix(w_ff, 4'd1, 4'd6,  west_ff.side_min);
   end

   // Take configuration writes and refresh thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= DW'(ssdr_pkg::RST_H);
         w_ff    <= DW'(ssdr_pkg::RST_W);
         hest_ff <= ssdr_pkg::HTHR_RST;
         west_ff <= ssdr_pkg::WTHR_RST;
         hthr_ff <= ssdr_pkg::HTHR_RST;
         wthr_ff <= ssdr_pkg::WTHR_RST;
      end else begin
         hthr_ff <= hthr_in;
         wthr_ff <= wthr_in;
         if (csr_write_enable && csr_index == ssdr_pkg::CSR_ROI_HEIGHT) begin
            h_ff              <= csr_dim;
            hest_ff.third     <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_THIRD);
            hest_ff.two_third <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_TWO_THIRD);
            hest_ff.mid_lo    <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_MID_LO);
            hest_ff.mid_hi    <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_MID_HI);
            hest_ff.top_min   <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_TOP_MIN);
            hest_ff.bot_min   <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_BOT_MIN);
            hest_ff.one_min   <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_H_ONE_MIN);
         end
         if (csr_write_enable && csr_index == ssdr_pkg::CSR_ROI_WIDTH) begin
            w_ff             <= csr_dim;
            west_ff.mid_lo   <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_W_MID_LO);
            west_ff.mid_hi   <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_W_MID_HI);
            west_ff.side_min <= ssdr_pkg::quot_est(csr_dim, ssdr_pkg::K_W_SIDE_MIN);
         end
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_acc) begin
         in_pixel_ff <= req_pixel;
         in_last_ff  <= req_last;
      end
   end

   // Probe counting and position advance
   assign pix_lit   = (in_pixel_ff == ssdr_pkg::PIX_LIT);
   assign pix_dark  = (in_pixel_ff == ssdr_pkg::PIX_DARK);
   assign half      = w_ff >> 1;
   assign in_roi    = (row_ff < h_ff) && (col_ff < w_ff);
   assign in_window = (row_ff >= hthr_ff.mid_lo) && (row_ff <= hthr_ff.mid_hi) &&
                      (col_ff >= wthr_ff.mid_lo) && (col_ff <= wthr_ff.mid_hi);

   always_comb begin
      row_upd  = row_ff;
      col_upd  = col_ff;
      top_upd  = top_ff;
      bot_upd  = bot_ff;
      full_upd = full_ff;
      for (int i = 0; i < 4; i++) begin
         side_upd[i] = side_ff[i];
      end
      mid_upd = mid_ff;
      if (proc) begin
         if (pix_lit && in_roi) begin
            if (col_ff == half) begin
               full_upd = ssdr_pkg::sat_inc(full_ff);
               if (row_ff < hthr_ff.third) begin
                  top_upd = ssdr_pkg::sat_inc(top_ff);
               end
               if (row_ff >= hthr_ff.two_third) begin
                  bot_upd = ssdr_pkg::sat_inc(bot_ff);
               end
            end
            if (row_ff == hthr_ff.third) begin
               if (col_ff < half) begin
                  side_upd[ssdr_pkg::SIDE_UL] = ssdr_pkg::sat_inc(side_ff[ssdr_pkg::SIDE_UL]);
               end else begin
                  side_upd[ssdr_pkg::SIDE_UR] = ssdr_pkg::sat_inc(side_ff[ssdr_pkg::SIDE_UR]);
               end
            end
            if (row_ff == hthr_ff.two_third) begin
               if (col_ff < half) begin
                  side_upd[ssdr_pkg::SIDE_LL] = ssdr_pkg::sat_inc(side_ff[ssdr_pkg::SIDE_LL]);
               end else begin
                  side_upd[ssdr_pkg::SIDE_LR] = ssdr_pkg::sat_inc(side_ff[ssdr_pkg::SIDE_LR]);
               end
            end
         end
         if (pix_dark && in_window) begin
            mid_upd = 1'b0;
         end
         // wrap the column at the width, hold the row at its limit
         if ({1'b0, col_ff} + 1'b1 >= {1'b0, w_ff}) begin
            col_upd = '0;
            if (row_ff < ssdr_pkg::DIM_MAX) begin
               row_upd = row_ff + 1'b1;
            end
         end else begin
            col_upd = col_ff + 1'b1;
         end
      end
   end

   // Clear the frame state after the last pixel
   always_comb begin
      row_in  = frame_end ? '0 : row_upd;
      col_in  = frame_end ? '0 : col_upd;
      top_in  = frame_end ? '0 : top_upd;
      bot_in  = frame_end ? '0 : bot_upd;
      full_in = frame_end ? '0 : full_upd;
      for (int i = 0; i < 4; i++) begin
         side_in[i] = frame_end ? '0 : side_upd[i];
      end
      mid_in = frame_end ? 1'b1 : mid_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         top_ff  <= '0;
         bot_ff  <= '0;
         full_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            side_ff[i] <= '0;
         end
         mid_ff <= 1'b1;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         full_ff <= full_in;
         for (int i = 0; i < 4; i++) begin
            side_ff[i] <= side_in[i];
         end
         mid_ff <= mid_in;
      end
   end

   // Segment flags from the final counts
   always_comb begin
      seg_in = '0;
      seg_in[ssdr_pkg::SEG_TOP] = top_upd > hthr_ff.top_min;
      seg_in[ssdr_pkg::SEG_MID] = mid_upd;
      seg_in[ssdr_pkg::SEG_BOT] = bot_upd > hthr_ff.bot_min;
      seg_in[ssdr_pkg::SEG_UL]  = side_upd[ssdr_pkg::SIDE_UL] > wthr_ff.side_min;
      seg_in[ssdr_pkg::SEG_UR]  = side_upd[ssdr_pkg::SIDE_UR] > wthr_ff.side_min;
      seg_in[ssdr_pkg::SEG_LL]  = side_upd[ssdr_pkg::SIDE_LL] > wthr_ff.side_min;
      seg_in[ssdr_pkg::SEG_LR]  = side_upd[ssdr_pkg::SIDE_LR] > wthr_ff.side_min;
   end

   // Decode the pattern; a full pattern is a one when the centre column is nearly solid
   always_comb begin
      rec_in = 1'b1;
      unique case (seg_in)
         ssdr_pkg::PAT_ALL: digit_in = (full_upd > hthr_ff.one_min) ? 4'd1 : 4'd8;
         ssdr_pkg::PAT_D0:  digit_in = 4'd0;
         ssdr_pkg::PAT_D2:  digit_in = 4'd2;
         ssdr_pkg::PAT_D3:  digit_in = 4'd3;
         ssdr_pkg::PAT_D4:  digit_in = 4'd4;
         ssdr_pkg::PAT_D5:  digit_in = 4'd5;
         ssdr_pkg::PAT_D6:  digit_in = 4'd6;
         ssdr_pkg::PAT_D7:  digit_in = 4'd7;
         ssdr_pkg::PAT_D9:  digit_in = 4'd9;
         default: begin
            digit_in = 4'd0;
            rec_in   = 1'b0;
         end
      endcase
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (frame_end) begin
         rsp_digit_ff <= digit_in;
         rsp_rec_ff   <= rec_in;
         rsp_seg_ff   <= seg_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit      = rsp_digit_ff;
   assign rsp_recognized = rsp_rec_ff;
   assign rsp_segments   = rsp_seg_ff;

   // Checks
   a_third_exact: assert property (@(posedge clock) disable iff (reset)
      $stable(h_ff) |-> ({2'b0, hthr_ff.third} * 12'd3 <= {2'b0, h_ff}) &&
                        ({2'b0, h_ff} < {2'b0, hthr_ff.third} * 12'd3 + 12'd3))
      else $error("height third threshold out of step with roi_height");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (top_ff <= full_ff) && (bot_ff <= full_ff))
      else $error("partial column count exceeds full column count");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (row_ff == '0) && (col_ff == '0) && mid_ff && (full_ff == '0))
      else $error("frame state not cleared after last pixel");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(in_valid_ff && in_last_ff))
      else $error("result raised without a last pixel");

   a_unrec_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rec_ff) |-> (rsp_digit_ff == 4'd0))
      else $error("unrecognised result carries a non-zero digit");

endmodule
